// ----- rtl/core/urd_pkg.sv -----
// Shared constants for the unsigned restoring divider.
`timescale 1ns / 1ps

package urd_pkg;

  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned WIDTH_DEFAULT = 32;

endpackage

// ----- rtl/core/unsigned_restoring_divider_core.sv -----
// Pipelined unsigned restoring divider, one stage per quotient bit.
//
//   word      valid          stall          payload
//   operand   operand_valid  operand_stall  dividend, divisor
//   result    result_valid   result_stall   quotient, remainder
//
// One word enters every cycle while operand_stall is low.
// The WIDTH step stages advance together; a stalled full last stage holds all.
// Reset clears the stage valid bits only.
// Division by zero gives an all-ones quotient and the dividend as remainder.
`timescale 1ns / 1ps

module unsigned_restoring_divider_core #(
  parameter int unsigned WIDTH = urd_pkg::WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        operand_valid,
  output logic                        operand_stall,
  input  logic [urd_pkg::FIELD_W-1:0] dividend,
  input  logic [urd_pkg::FIELD_W-1:0] divisor,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [urd_pkg::FIELD_W-1:0] quotient,
  output logic [urd_pkg::FIELD_W-1:0] remainder
);

  localparam int unsigned FW = urd_pkg::FIELD_W;

  logic             vld [0:WIDTH];
  logic [WIDTH-1:0] rem [0:WIDTH];
  logic [WIDTH-1:0] quo [0:WIDTH];
  logic [WIDTH-1:0] den [0:WIDTH];
  logic             en;

  assign en            = ~(vld[WIDTH] & result_stall);
  assign operand_stall = ~en;

  assign vld[0] = operand_valid;
  assign rem[0] = '0;

  generate
    if (WIDTH <= FW) begin : g_in_narrow
      assign quo[0] = dividend[WIDTH-1:0];
      assign den[0] = divisor[WIDTH-1:0];
    end else begin : g_in_wide
      assign quo[0] = {{(WIDTH-FW){1'b0}}, dividend};
      assign den[0] = {{(WIDTH-FW){1'b0}}, divisor};
    end
  endgenerate

  generate
    for (genvar i = 0; i < WIDTH; i++) begin : g_step
      urd_stage #(
        .WIDTH(WIDTH)
      ) u_stage (
        .clk        (clk),
        .rst        (rst),
        .en         (en),
        .prev_valid (vld[i]),
        .prev_rem   (rem[i]),
        .prev_quo   (quo[i]),
        .prev_den   (den[i]),
        .valid      (vld[i+1]),
        .rem        (rem[i+1]),
        .quo        (quo[i+1]),
        .den        (den[i+1])
      );
    end
  endgenerate

  assign result_valid = vld[WIDTH];

  generate
    if (WIDTH >= FW) begin : g_out_wide
      assign quotient  = quo[WIDTH][FW-1:0];
      assign remainder = rem[WIDTH][FW-1:0];
    end else begin : g_out_narrow
      assign quotient  = {{(FW-WIDTH){1'b0}}, quo[WIDTH]};
      assign remainder = {{(FW-WIDTH){1'b0}}, rem[WIDTH]};
    end
  endgenerate

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (vld[WIDTH] && den[WIDTH] != '0) |-> (rem[WIDTH] < den[WIDTH]))
    else $error("remainder not below divisor");

  a_div_zero_ones: assert property (@(posedge clk) disable iff (rst)
    (vld[WIDTH] && den[WIDTH] == '0) |-> (quo[WIDTH] == '1))
    else $error("divide by zero quotient not all ones");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[WIDTH] && result_stall) |=> (vld[WIDTH] && $stable(quo[WIDTH])
      && $stable(rem[WIDTH])))
    else $error("last stage changed while stalled");
`endif

endmodule

// ----- rtl/core/urd_stage.sv -----
// One quotient-bit step of the restoring divider, registered.
`timescale 1ns / 1ps

module urd_stage #(
  parameter int unsigned WIDTH = urd_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             prev_valid,
  input  logic [WIDTH-1:0] prev_rem,
  input  logic [WIDTH-1:0] prev_quo,
  input  logic [WIDTH-1:0] prev_den,
  output logic             valid,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] den
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;

  // partial remainder with guard bit, next dividend bit shifted in
  assign shifted  = {prev_rem, prev_quo[WIDTH-1]};
  assign diff     = shifted - {1'b0, prev_den};
  assign fits     = ~diff[WIDTH];
  assign rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign quo_next = {prev_quo[WIDTH-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      quo <= quo_next;
      den <= prev_den;
    end
  end

endmodule
